/* rtl/fhp_pkg.sv */
// ---------------------------------------------------------------------------
// Fragment header parser package
// Shared types, phase and result codes, and character constants.
// ---------------------------------------------------------------------------
package fhp_pkg;

	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [7:0] SEP_CHAR   = 8'd58;
	localparam logic [7:0] DIGIT_BASE = 8'd48;

	typedef enum logic [2:0] {
		PH_TOTAL   = 3'd0,
		PH_FRAG    = 3'd1,
		PH_SIZE    = 3'd2,
		PH_NAME    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	localparam logic [1:0] KIND_NAME    = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_HEADER  = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  result_byte;
		logic [15:0] total_fragments;
		logic [15:0] fragment_number;
		logic [15:0] payload_size;
		logic        number_overflow;
		logic        last_of_packet;
		logic        final_fragment;
	} out_item_t;

endpackage

/* rtl/fhp_dec_acc.sv */
// ---------------------------------------------------------------------------
// Decimal accumulator step
// Computes value*10 + byte - '0' modulo 2^COUNT_WIDTH and flags a wrap.
// ---------------------------------------------------------------------------
module fhp_dec_acc #(
	parameter int COUNT_WIDTH = fhp_pkg::COUNT_WIDTH_DEF
) (
	input  logic [COUNT_WIDTH-1:0] value,
	input  logic [7:0]             digit,
	output logic [COUNT_WIDTH-1:0] sum,
	output logic                   wrap
);
	import fhp_pkg::*;

	localparam int TW = COUNT_WIDTH + 4;

	logic [TW-1:0] times_ten;
	logic [TW-1:0] raw;
	logic [TW-1:0] diff;

	// Times ten is built from two shifts; the sum cannot exceed TW bits.
	assign times_ten = (TW'(value) << 3) + (TW'(value) << 1);
	assign raw       = times_ten + TW'(digit);
	assign diff      = raw - TW'(DIGIT_BASE);
	assign sum       = diff[COUNT_WIDTH-1:0];

	// A wrap is either a negative result or one that spills above the field.
	assign wrap = (raw < TW'(DIGIT_BASE)) || (diff[TW-1:COUNT_WIDTH] != '0);

endmodule

/* rtl/fhp_parser.sv */
// ---------------------------------------------------------------------------
// Fragment header parse stage
// Holds the parse state and turns one byte into at most one result word.
// ---------------------------------------------------------------------------
module fhp_parser #(
	parameter int COUNT_WIDTH = fhp_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  fhp_pkg::in_item_t  item,
	output logic               has_result,
	output fhp_pkg::out_item_t res
);
	import fhp_pkg::*;

	phase_t                 phase_q, phase_d, ph;
	logic [COUNT_WIDTH-1:0] total_q, frag_q, size_q, count_q;
	logic [COUNT_WIDTH-1:0] total_d, frag_d, size_d, count_d;
	logic [COUNT_WIDTH-1:0] tot, frag, size, count, count_inc;
	logic                   ovf_q, ovf_d, ovf;
	logic [COUNT_WIDTH-1:0] acc_in, acc_out;
	logic                   acc_wrap;
	logic                   is_sep, is_last, size_zero;
	logic [31:0]            tot_x, frag_x, size_x;

	// A first mark clears the state before the byte is parsed.
	assign ph    = item.first ? PH_TOTAL : phase_q;
	assign tot   = item.first ? '0 : total_q;
	assign frag  = item.first ? '0 : frag_q;
	assign size  = item.first ? '0 : size_q;
	assign count = item.first ? '0 : count_q;
	assign ovf   = item.first ? 1'b0 : ovf_q;

	assign is_sep    = (item.data_byte == SEP_CHAR);
	assign count_inc = count + COUNT_WIDTH'(1);
	assign is_last   = (count_inc == size);
	assign size_zero = (size == '0);

	assign tot_x  = 32'(tot);
	assign frag_x = 32'(frag);
	assign size_x = 32'(size);

	always_comb begin
		unique case (ph)
			PH_TOTAL: acc_in = tot;
			PH_FRAG:  acc_in = frag;
			default:  acc_in = size;
		endcase
	end

	fhp_dec_acc #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_acc (
		.value(acc_in),
		.digit(item.data_byte),
		.sum  (acc_out),
		.wrap (acc_wrap)
	);

	// Next state
	always_comb begin
		phase_d = ph;
		total_d = tot;
		frag_d  = frag;
		size_d  = size;
		count_d = count;
		ovf_d   = ovf;
		unique case (ph)
			PH_TOTAL: begin
				if (is_sep) phase_d = PH_FRAG;
				else begin
					total_d = acc_out;
					ovf_d   = ovf | acc_wrap;
				end
			end
			PH_FRAG: begin
				if (is_sep) phase_d = PH_SIZE;
				else begin
					frag_d = acc_out;
					ovf_d  = ovf | acc_wrap;
				end
			end
			PH_SIZE: begin
				if (is_sep) phase_d = PH_NAME;
				else begin
					size_d = acc_out;
					ovf_d  = ovf | acc_wrap;
				end
			end
			PH_NAME: begin
				if (is_sep) begin
					count_d = '0;
					phase_d = size_zero ? PH_DONE : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				count_d = count_inc;
				if (is_last) phase_d = PH_DONE;
			end
			default: begin
			end
		endcase
	end

	// Outputs
	always_comb begin
		has_result      = 1'b0;
		res             = '0;
		res.number_overflow = ovf;
		unique case (ph)
			PH_NAME: begin
				has_result = 1'b1;
				if (is_sep) begin
					res.result_kind     = KIND_HEADER;
					res.total_fragments = tot_x[15:0];
					res.fragment_number = frag_x[15:0];
					res.payload_size    = size_x[15:0];
					res.last_of_packet  = size_zero;
					res.final_fragment  = (frag == tot);
				end else begin
					res.result_kind = KIND_NAME;
					res.result_byte = item.data_byte;
				end
			end
			PH_PAYLOAD: begin
				has_result         = 1'b1;
				res.result_kind    = KIND_PAYLOAD;
				res.result_byte    = item.data_byte;
				res.last_of_packet = is_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOTAL;
			total_q <= '0;
			frag_q  <= '0;
			size_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			total_q <= total_d;
			frag_q  <= frag_d;
			size_q  <= size_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

/* rtl/fragment_header_parser_top.sv */
// ---------------------------------------------------------------------------
// Fragment header parser
// A byte waits in the input register; its word goes from the single parse
// stage, which closes the parse state loop, into the result register.
// Throughput: one byte per cycle while no held result blocks a new word.
// Reset: arst_n clears the parse state to the total field, all counts and
// the overflow flag to zero, and empties both registers.
// ---------------------------------------------------------------------------
module fragment_header_parser_top #(
	parameter int COUNT_WIDTH = fhp_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               dgram_valid,
	output logic               dgram_ready,
	input  fhp_pkg::in_item_t  dgram,
	output logic               result_valid,
	input  logic               result_ready,
	output fhp_pkg::out_item_t result
);
	import fhp_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_q;
	logic      res_valid_q;
	out_item_t res_d;
	logic      has_result;
	logic      slot_free;
	logic      step;

	assign slot_free   = !res_valid_q || result_ready;
	// A byte that yields no word may move on even while the result is held.
	assign step        = valid_s1 && (!has_result || slot_free);
	assign dgram_ready = !valid_s1 || step;

	fhp_parser #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.has_result(has_result),
		.res       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (dgram_ready) begin
			valid_s1 <= dgram_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dgram_ready && dgram_valid) begin
			item_s1 <= dgram;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && has_result) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_result) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> dgram_ready)
		else $error("input register empty but byte refused");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(item_s1))
		else $error("stalled byte lost from input register");

	a_final_header: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.final_fragment |-> result.result_kind == KIND_HEADER)
		else $error("final fragment flag outside a header word");

	a_name_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == KIND_NAME
		|-> !result.last_of_packet && result.total_fragments == 16'd0)
		else $error("name word carries header fields");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		step && has_result |-> slot_free)
		else $error("result register overwritten while held");

endmodule
